// ===== rtl/lcs_pkg.sv =====
// shared constants, types and helpers for the line centroid steering block
package lcs_pkg;

  // sensor array and field widths
  localparam int SENSOR_COUNT        = 8;
  localparam int SAMPLE_BITS_DEFAULT = 10;
  localparam int THRESH_W            = 10;
  localparam int SPEED_W             = 8;
  localparam int GAIN_W              = 8;

  // derived arithmetic widths
  localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
  localparam int DEN_W  = CNT_W + 1;
  localparam int POS_W  = $clog2(SENSOR_COUNT) + 1;
  localparam int MAG_W  = $clog2((SENSOR_COUNT * SENSOR_COUNT) / 4 + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int PROD_W = GAIN_W + MAG_W;
  localparam int CALC_W = PROD_W + 2;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_THRESHOLD = 4'd0,
    REG_BASE_SPEED     = 4'd1,
    REG_MAX_SPEED      = 4'd2,
    REG_TURN_GAIN      = 4'd3
  } cfg_reg_t;

  localparam logic [THRESH_W-1:0] LINE_THRESHOLD_RESET = 10'd500;
  localparam logic [SPEED_W-1:0]  BASE_SPEED_RESET     = 8'd150;
  localparam logic [SPEED_W-1:0]  MAX_SPEED_RESET      = 8'd255;
  localparam logic [GAIN_W-1:0]   TURN_GAIN_RESET      = 8'd35;

  // merged scan summary handed to the divide step
  typedef struct packed {
    logic              seen;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [DEN_W-1:0]  den;
  } lcs_merge_t;

  // doubled sensor position 2*idx - (count-1)
  function automatic logic signed [POS_W-1:0] sensor_position(input int idx);
    return POS_W'(2 * idx - (SENSOR_COUNT - 1));
  endfunction

endpackage

// ===== rtl/lcs_lane.sv =====
// one sensor lane: threshold compare and signed position contribution
module lcs_lane #(
  parameter int SAMPLE_BITS = 10,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [lcs_pkg::THRESH_W-1:0]       threshold,
  output logic                               on_line,
  output logic signed [lcs_pkg::POS_W-1:0]   pos
);
  import lcs_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  always_ff @(posedge clk) begin
    if (load) begin
      on_line <= CMP_W'(sample) < CMP_W'(threshold);
    end
  end

  assign pos = on_line ? sensor_position(INDEX) : '0;

endmodule

// ===== rtl/lcs_merge.sv =====
// merge of lane results: on-line count, position sum, gain product
module lcs_merge (
  input  logic [lcs_pkg::SENSOR_COUNT-1:0]                  on_line,
  input  logic signed [lcs_pkg::SENSOR_COUNT-1:0][lcs_pkg::POS_W-1:0] pos,
  input  logic [lcs_pkg::GAIN_W-1:0]                        gain,
  output lcs_pkg::lcs_merge_t                                summary
);
  import lcs_pkg::*;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [MAG_W-1:0]        mag;

  always_comb begin
    count = '0;
    sum   = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      count = count + CNT_W'(on_line[i]);
      sum   = sum + SUM_W'($signed(pos[i]));
    end
  end

  // magnitude for an unsigned divide, sign applied afterwards (truncate toward zero)
  assign mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

  assign summary.seen = (count != '0);
  assign summary.neg  = sum[SUM_W-1];
  assign summary.prod = PROD_W'(gain) * PROD_W'(mag);
  assign summary.den  = {count, 1'b0};

endmodule

// ===== rtl/lcs_divider.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
module lcs_divider #(
  parameter int DIVIDEND_W = 13,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVIDEND_W-1:0] quo;
  logic [STEP_W-1:0]     steps;
  logic                  busy;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      rem       <= '0;
      quo       <= dividend;
      divisor_q <= divisor;
      steps     <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      rem   <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo   <= {quo[DIVIDEND_W-2:0], fits};
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/line_centroid_steering.sv =====
// top level: proportional line-follower steering from one sensor scan
// a scan passes from the lane flag registers through the merge state and the divider to out_valid
// scans are taken one at a time, paced by the 13-step shift-subtract divider
// the result sits in an output register, so the next scan is taken while it waits
// reset (rst, synchronous): configuration registers return to defaults, search direction turns right,
// no result is pending
module line_centroid_steering #(
  parameter int SAMPLE_BITS = lcs_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // scan input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          sample_0,
  input  logic [SAMPLE_BITS-1:0]          sample_1,
  input  logic [SAMPLE_BITS-1:0]          sample_2,
  input  logic [SAMPLE_BITS-1:0]          sample_3,
  input  logic [SAMPLE_BITS-1:0]          sample_4,
  input  logic [SAMPLE_BITS-1:0]          sample_5,
  input  logic [SAMPLE_BITS-1:0]          sample_6,
  input  logic [SAMPLE_BITS-1:0]          sample_7,
  // drive output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lcs_pkg::SPEED_W-1:0]     left_drive,
  output logic [lcs_pkg::SPEED_W-1:0]     right_drive,
  output logic                            line_seen,
  // register write port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_DIV
  } state_t;

  state_t state;

  // configuration registers
  logic [THRESH_W-1:0] thresh_level;
  logic [SPEED_W-1:0]  cruise_level;
  logic [SPEED_W-1:0]  drive_cap;
  logic [GAIN_W-1:0]   steer_gain;

  // search direction memory: set when the last tracked error was negative
  logic last_was_left;

  // summary bits held across the divide
  logic seen_q;
  logic neg_q;

  logic                                      accept;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0]  samples;
  logic [SENSOR_COUNT-1:0]                   on_line;
  logic signed [SENSOR_COUNT-1:0][POS_W-1:0] pos;
  lcs_merge_t                                summary;
  logic                                      div_done;
  logic [PROD_W-1:0]                         quotient;
  logic                                      out_free;
  logic                                      out_load;

  // drive arithmetic
  logic signed [CALC_W-1:0] corr;
  logic signed [CALC_W-1:0] base_ext;
  logic signed [CALC_W-1:0] left_raw;
  logic signed [CALC_W-1:0] right_raw;
  logic [SPEED_W-1:0]       left_clamped;
  logic [SPEED_W-1:0]       right_clamped;

  // one scan at a time; busy from the transaction until its result is registered
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  // output register can take a new result when empty or being drained this cycle
  assign out_free  = !out_valid || !out_stall;
  // finished divide moves into the output register this cycle
  assign out_load  = (state == S_DIV) && div_done && out_free;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  // one lane per sensor, flags captured with the input transaction
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lcs_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX       (g)
    ) u_lane (
      .clk       (clk),
      .load      (accept),
      .sample    (samples[g]),
      .threshold (thresh_level),
      .on_line   (on_line[g]),
      .pos       (pos[g])
    );
  end

  // count, position sum and gain product across the lanes
  lcs_merge u_merge (
    .on_line (on_line),
    .pos     (pos),
    .gain    (steer_gain),
    .summary (summary)
  );

  // gain*|sum| / (2*count); a zero count gives a don't-care quotient
  lcs_divider #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MERGE),
    .dividend (summary.prod),
    .divisor  (summary.den),
    .done     (div_done),
    .quotient (quotient)
  );

  // signed correction, then base -/+ correction clamped to 0..drive cap
  always_comb begin
    corr      = neg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    base_ext  = $signed({{(CALC_W - SPEED_W){1'b0}}, cruise_level});
    left_raw  = base_ext - corr;
    right_raw = base_ext + corr;

    if (left_raw < 0) begin
      left_clamped = '0;
    end else if (left_raw > $signed({{(CALC_W - SPEED_W){1'b0}}, drive_cap})) begin
      left_clamped = drive_cap;
    end else begin
      left_clamped = left_raw[SPEED_W-1:0];
    end

    if (right_raw < 0) begin
      right_clamped = '0;
    end else if (right_raw > $signed({{(CALC_W - SPEED_W){1'b0}}, drive_cap})) begin
      right_clamped = drive_cap;
    end else begin
      right_clamped = right_raw[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      thresh_level  <= LINE_THRESHOLD_RESET;
      cruise_level  <= BASE_SPEED_RESET;
      drive_cap     <= MAX_SPEED_RESET;
      steer_gain    <= TURN_GAIN_RESET;
      last_was_left <= 1'b0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LINE_THRESHOLD: thresh_level <= cfg_data[THRESH_W-1:0];
          REG_BASE_SPEED:     cruise_level <= cfg_data[SPEED_W-1:0];
          REG_MAX_SPEED:      drive_cap    <= cfg_data[SPEED_W-1:0];
          REG_TURN_GAIN:      steer_gain   <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          // divider starts this cycle from the merged summary
          seen_q <= summary.seen;
          neg_q  <= summary.neg;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            line_seen <= seen_q;
            if (seen_q) begin
              left_drive    <= left_clamped;
              right_drive   <= right_clamped;
              last_was_left <= neg_q;
            end else if (last_was_left) begin
              // line lost, spin toward the left
              left_drive  <= '0;
              right_drive <= cruise_level;
            end else begin
              // line lost, spin toward the right
              left_drive  <= cruise_level;
              right_drive <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a scan taken in makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after a scan transaction");

  // starting the divider clears any stale completion
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |=> !div_done)
    else $error("divider done flag survived a start");

  // a finished divide with room in the output register yields a result
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished scan did not reach the output register");

  // a search result always stops one wheel
  a_search_spin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !line_seen) |-> (left_drive == '0 || right_drive == '0))
    else $error("search result drives both wheels");

endmodule
